[rtl/utf8v_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// utf8v_pkg
// Shared types and constants for the UTF-8 message validator.
// ----------------------------------------------------------------------------
package utf8v_pkg;

  typedef enum logic [2:0] {
    REASON_OK       = 3'd0,
    REASON_EMPTY    = 3'd1,
    REASON_TOO_LONG = 3'd2,
    REASON_BAD_ENC  = 3'd3,
    REASON_BLANK    = 3'd4
  } reason_e;

  localparam logic [15:0] MAX_LENGTH_RESET = 16'd1024;

  localparam logic [7:0] ASCII_MASK = 8'h80;
  localparam logic [7:0] CONT_MASK  = 8'hC0;
  localparam logic [7:0] CONT_TAG   = 8'h80;
  localparam logic [7:0] LEAD2_MASK = 8'hE0;
  localparam logic [7:0] LEAD2_TAG  = 8'hC0;
  localparam logic [7:0] LEAD3_MASK = 8'hF0;
  localparam logic [7:0] LEAD3_TAG  = 8'hE0;
  localparam logic [7:0] LEAD4_MASK = 8'hF8;
  localparam logic [7:0] LEAD4_TAG  = 8'hF0;

  localparam logic [7:0] CHAR_TAB   = 8'd9;
  localparam logic [7:0] CHAR_LF    = 8'd10;
  localparam logic [7:0] CHAR_CR    = 8'd13;
  localparam logic [7:0] CHAR_SPACE = 8'd32;

  function automatic logic is_c_space(input logic [7:0] b);
    is_c_space = (b == CHAR_SPACE) || ((b >= CHAR_TAB) && (b <= CHAR_CR));
  endfunction

endpackage

[rtl/utf8_message_validator.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// utf8_message_validator
// Checks a byte stream message for UTF-8 structure, control bytes, length
// and whitespace-only content; one verdict item per message.
// ----------------------------------------------------------------------------
//  channel   direction  handshake                payload
//  in        input      in_valid_i / in_stall_o  data_byte, has_byte, end_of_message
//  out       output     out_valid_o / out_stall_i message_ok, reject_reason
//  cfg       input      cfg_we_i                 cfg_wdata_i (max_length)
//
//  One item per cycle sustained unless a held verdict stalls a message's last
//  item; that item is held in the input register, then its verdict in the result register.
//  Message state updates as an item leaves the input register.
//  A held verdict stalls only items that end a message; others pass on.
//  Reset clears message state and sets max_length to 1024.
// ----------------------------------------------------------------------------
module utf8_message_validator #(
  parameter int COUNT_BITS = 16
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     cfg_we_i,
  input  logic [15:0]              cfg_wdata_i,
  input  logic                     in_valid_i,
  output logic                     in_stall_o,
  input  logic [7:0]               data_byte_i,
  input  logic                     has_byte_i,
  input  logic                     end_of_message_i,
  output logic                     out_valid_o,
  input  logic                     out_stall_i,
  output logic                     message_ok_o,
  output logic [2:0]               reject_reason_o
);
  import utf8v_pkg::*;

  localparam int CNT_W = COUNT_BITS + 1;
  localparam int CMP_W = (CNT_W > 16) ? CNT_W : 16;

  logic [15:0]      max_length_q;
  logic             s1_valid_q, s1_valid_d;
  logic [7:0]       s1_data_q;
  logic             s1_has_q, s1_eom_q;
  logic             out_valid_q, out_valid_d;
  logic             out_ok_q;
  reason_e          out_reason_q, reason;

  logic [1:0]       pend_q, pend_d;
  logic             err_q, err_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic             nsp_q, nsp_d;

  logic             out_free, s1_go, in_load;
  logic [CMP_W-1:0] cap, lim, cnt_ext, maxl_ext;

  assign out_free   = !out_valid_q || !out_stall_i;
  assign s1_go      = s1_valid_q && (!s1_eom_q || out_free);
  assign in_stall_o = s1_valid_q && !s1_go;
  assign in_load    = in_valid_i && !in_stall_o;

  always_comb begin
    s1_valid_d = s1_valid_q;
    if (in_load) begin
      s1_valid_d = 1'b1;
    end else if (s1_go) begin
      s1_valid_d = 1'b0;
    end
    out_valid_d = out_valid_q;
    if (s1_go && s1_eom_q) begin
      out_valid_d = 1'b1;
    end else if (out_free) begin
      out_valid_d = 1'b0;
    end
  end

  // byte decode
  always_comb begin
    pend_d = pend_q;
    err_d  = err_q;
    cnt_d  = cnt_q;
    nsp_d  = nsp_q;
    if (s1_has_q) begin
      if (!cnt_q[COUNT_BITS]) begin
        cnt_d = cnt_q + CNT_W'(1);
      end
      if (!is_c_space(s1_data_q)) begin
        nsp_d = 1'b1;
      end
      if (!err_q) begin
        if (pend_q != 2'd0) begin
          if ((s1_data_q & CONT_MASK) == CONT_TAG) begin
            pend_d = pend_q - 2'd1;
          end else begin
            err_d  = 1'b1;
            pend_d = 2'd0;
          end
        end else begin
          priority if ((s1_data_q & ASCII_MASK) == 8'd0) begin
            if ((s1_data_q < CHAR_SPACE) && (s1_data_q != CHAR_TAB) &&
                (s1_data_q != CHAR_LF) && (s1_data_q != CHAR_CR)) begin
              err_d = 1'b1;
            end
          end else if ((s1_data_q & LEAD2_MASK) == LEAD2_TAG) begin
            pend_d = 2'd1;
          end else if ((s1_data_q & LEAD3_MASK) == LEAD3_TAG) begin
            pend_d = 2'd2;
          end else if ((s1_data_q & LEAD4_MASK) == LEAD4_TAG) begin
            pend_d = 2'd3;
          end else begin
            err_d = 1'b1;
          end
        end
      end
    end
  end

  // verdict on the updated state
  assign cap      = (CMP_W'(1) << COUNT_BITS) - CMP_W'(1);
  assign maxl_ext = CMP_W'(max_length_q);
  assign lim      = (maxl_ext > cap) ? cap : maxl_ext;
  assign cnt_ext  = CMP_W'(cnt_d);

  always_comb begin
    priority if (cnt_d == '0) begin
      reason = REASON_EMPTY;
    end else if (cnt_ext > lim) begin
      reason = REASON_TOO_LONG;
    end else if (err_d || (pend_d != 2'd0)) begin
      reason = REASON_BAD_ENC;
    end else if (!nsp_d) begin
      reason = REASON_BLANK;
    end else begin
      reason = REASON_OK;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_length_q <= MAX_LENGTH_RESET;
      s1_valid_q   <= 1'b0;
      out_valid_q  <= 1'b0;
      pend_q       <= 2'd0;
      err_q        <= 1'b0;
      cnt_q        <= '0;
      nsp_q        <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        max_length_q <= cfg_wdata_i;
      end
      s1_valid_q  <= s1_valid_d;
      out_valid_q <= out_valid_d;
      if (s1_go) begin
        if (s1_eom_q) begin
          pend_q <= 2'd0;
          err_q  <= 1'b0;
          cnt_q  <= '0;
          nsp_q  <= 1'b0;
        end else begin
          pend_q <= pend_d;
          err_q  <= err_d;
          cnt_q  <= cnt_d;
          nsp_q  <= nsp_d;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_load) begin
      s1_data_q <= data_byte_i;
      s1_has_q  <= has_byte_i;
      s1_eom_q  <= end_of_message_i;
    end
    if (s1_go && s1_eom_q) begin
      out_ok_q     <= (reason == REASON_OK);
      out_reason_q <= reason;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign message_ok_o    = out_ok_q;
  assign reject_reason_o = out_reason_q;

endmodule

[rtl/utf8v_checker.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// utf8v_checker
// Port-level checks for the UTF-8 message validator, bound to the top level.
// ----------------------------------------------------------------------------
module utf8v_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       out_valid_o,
  input logic       out_stall_i,
  input logic       message_ok_o,
  input logic [2:0] reject_reason_o
);
  import utf8v_pkg::*;

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(reject_reason_o)
      && $stable(message_ok_o))
    else $error("verdict changed while stalled");

  a_ok_match: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (message_ok_o == (reject_reason_o == REASON_OK)))
    else $error("message_ok disagrees with reject_reason");

  a_reason_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (reject_reason_o == REASON_OK || reject_reason_o == REASON_EMPTY
      || reject_reason_o == REASON_TOO_LONG || reject_reason_o == REASON_BAD_ENC
      || reject_reason_o == REASON_BLANK))
    else $error("reject_reason out of range");

endmodule

bind utf8_message_validator utf8v_checker u_utf8v_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .out_valid_o     (out_valid_o),
  .out_stall_i     (out_stall_i),
  .message_ok_o    (message_ok_o),
  .reject_reason_o (reject_reason_o)
);
